FILE: rtl/lpg_pkg.sv
`timescale 1ns / 1ps

package lpg_pkg;

  // Coordinate and payload widths.
  localparam int COORD_W = 10;
  localparam int ERR_W   = COORD_W + 2;
  localparam int COLOR_W = 16;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_FIELDS_W  = 4 * COORD_W + COLOR_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * COORD_W + COLOR_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration register map.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = COORD_W'(320);
  localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = COORD_W'(240);

  // Request kinds carried in tuser.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // Line state prepared from a start request.
  typedef struct packed {
    logic               steep;
    logic [COORD_W-1:0] major_pos;
    logic [COORD_W-1:0] major_end;
    logic [COORD_W-1:0] minor_pos;
    logic               minor_dir_down;
    logic [COORD_W-1:0] delta_major;
    logic [COORD_W-1:0] delta_minor;
    logic [ERR_W-1:0]   error_term;
  } line_setup_t;

endpackage

FILE: rtl/line_pixel_generator.sv
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                        tuser / tlast
// s_axis    in   start_x, start_y, end_x, end_y, line_color  tuser: req_type
// m_axis    out  pixel_x, pixel_y, pixel_color              tuser: visible, tlast: last_pixel
// cfg       in   cfg_addr 0 = screen_width, 1 = screen_height
//
// A request is taken when s_axis_tready is high; a step produces its pixel in the
// output register on the following cycle, one pixel per clock while m_axis_tready is high.
// The error update is one subtract plus one add on the line state registers.
// Reset (synchronous, rst high) idles the line and sets the screen to 320 x 240.
// Input is accepted while the output register is empty or being drained.
module line_pixel_generator (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // start_x, start_y, end_x, end_y, line_color
  input  logic [lpg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // req_type
  input  logic [0:0]                       s_axis_tuser,

  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [lpg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // visible
  output logic [0:0]                       m_axis_tuser,
  output logic                             m_axis_tlast,

  input  logic                             cfg_we,
  input  logic [lpg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lpg_pkg::COORD_W-1:0]      cfg_wdata
);

  localparam int CW = lpg_pkg::COORD_W;
  localparam int EW = lpg_pkg::ERR_W;

  // Screen size registers.
  logic [CW-1:0] screen_width;
  logic [CW-1:0] screen_height;

  // Line state.
  logic                        active;
  logic                        steep_flag;
  logic [CW-1:0]               major_pos;
  logic [CW-1:0]               major_end;
  logic [CW-1:0]               minor_pos;
  logic                        minor_dir_down;
  logic [CW-1:0]               delta_major;
  logic [CW-1:0]               delta_minor;
  logic [EW-1:0]               error_term;
  logic [lpg_pkg::COLOR_W-1:0] held_color;

  // Output register.
  logic [CW-1:0]               pixel_x;
  logic [CW-1:0]               pixel_y;
  logic [lpg_pkg::COLOR_W-1:0] pixel_color;
  logic                        visible;
  logic                        last_pixel;

  logic                 in_fire;
  logic                 start_fire;
  logic                 step_fire;
  lpg_pkg::line_setup_t setup;
  logic [CW-1:0]        px;
  logic [CW-1:0]        py;
  logic                 at_end;
  logic [EW:0]          err_sub;
  logic [EW:0]          err_adj;
  logic [CW-1:0]        minor_pos_next;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign start_fire    = in_fire && (s_axis_tuser[0] == lpg_pkg::REQ_START);
  assign step_fire     = in_fire && (s_axis_tuser[0] == lpg_pkg::REQ_STEP) && active;

  lpg_line_setup u_setup (
    .start_x (s_axis_tdata[0*CW +: CW]),
    .start_y (s_axis_tdata[1*CW +: CW]),
    .end_x   (s_axis_tdata[2*CW +: CW]),
    .end_y   (s_axis_tdata[3*CW +: CW]),
    .setup   (setup)
  );

  // Current pixel with the axes put back.
  assign px     = steep_flag ? minor_pos : major_pos;
  assign py     = steep_flag ? major_pos : minor_pos;
  assign at_end = major_pos == major_end;

  // Error update, one bit wider so the sign test is exact.
  assign err_sub = {error_term[EW-1], error_term} - {(EW + 1 - CW)'(0), delta_minor};
  assign err_adj = err_sub[EW] ? err_sub + {(EW + 1 - CW)'(0), delta_major} : err_sub;
  assign minor_pos_next = !err_sub[EW] ? minor_pos :
                          (minor_dir_down ? minor_pos - CW'(1) : minor_pos + CW'(1));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lpg_pkg::SCREEN_WIDTH_RST;
      screen_height <= lpg_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        lpg_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_wdata;
        lpg_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Line state: loaded on start, advanced on each step.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start_fire) begin
      active <= 1'b1;
    end else if (step_fire && at_end) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_fire) begin
      steep_flag     <= setup.steep;
      major_pos      <= setup.major_pos;
      major_end      <= setup.major_end;
      minor_pos      <= setup.minor_pos;
      minor_dir_down <= setup.minor_dir_down;
      delta_major    <= setup.delta_major;
      delta_minor    <= setup.delta_minor;
      error_term     <= setup.error_term;
      held_color     <= s_axis_tdata[4*CW +: lpg_pkg::COLOR_W];
    end else if (step_fire) begin
      major_pos  <= major_pos + CW'(1);
      minor_pos  <= minor_pos_next;
      error_term <= err_adj[EW-1:0];
    end
  end

  // Output register: filled by a step, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      pixel_x     <= px;
      pixel_y     <= py;
      pixel_color <= held_color;
      visible     <= (px < screen_width) && (py < screen_height);
      last_pixel  <= at_end;
    end
  end

  assign m_axis_tdata = {(lpg_pkg::OUT_TDATA_W - lpg_pkg::OUT_FIELDS_W)'(0),
                         pixel_color, pixel_y, pixel_x};
  assign m_axis_tuser = visible;
  assign m_axis_tlast = last_pixel;

`ifndef ASSERT_OFF
  // A step on the end pixel closes the line.
  a_end_idles: assert property (@(posedge clk) disable iff (rst)
    (step_fire && at_end && !start_fire) |=> !active)
    else $error("line still active after its last pixel");

  // A start request always opens a line.
  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    start_fire |=> active)
    else $error("start request did not activate the line");

  // The error term never goes negative while a line runs.
  a_err_nonneg: assert property (@(posedge clk) disable iff (rst)
    active |-> !error_term[EW-1])
    else $error("error term negative during a line");

  // The minor delta never exceeds the major delta.
  a_delta_order: assert property (@(posedge clk) disable iff (rst)
    active |-> (delta_minor <= delta_major))
    else $error("minor delta exceeds major delta");

  // A new pixel appears only after an accepted step.
  a_pixel_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(step_fire))
    else $error("pixel produced without a step");
`endif

endmodule

FILE: rtl/lpg_line_setup.sv
`timescale 1ns / 1ps

// Turns two endpoints into the per-line state: picks the major axis,
// orders the endpoints along it and seeds the error term.
module lpg_line_setup (
  input  logic [lpg_pkg::COORD_W-1:0] start_x,
  input  logic [lpg_pkg::COORD_W-1:0] start_y,
  input  logic [lpg_pkg::COORD_W-1:0] end_x,
  input  logic [lpg_pkg::COORD_W-1:0] end_y,
  output lpg_pkg::line_setup_t        setup
);

  logic [lpg_pkg::COORD_W-1:0] dx;
  logic [lpg_pkg::COORD_W-1:0] dy;
  logic                        steep;
  logic [lpg_pkg::COORD_W-1:0] a1;
  logic [lpg_pkg::COORD_W-1:0] b1;
  logic [lpg_pkg::COORD_W-1:0] a2;
  logic [lpg_pkg::COORD_W-1:0] b2;
  logic                        swap_ends;
  logic [lpg_pkg::COORD_W-1:0] lo_a;
  logic [lpg_pkg::COORD_W-1:0] lo_b;
  logic [lpg_pkg::COORD_W-1:0] hi_a;
  logic [lpg_pkg::COORD_W-1:0] hi_b;

  // Absolute distances along each axis.
  assign dx = (start_x > end_x) ? start_x - end_x : end_x - start_x;
  assign dy = (start_y > end_y) ? start_y - end_y : end_y - start_y;

  // A steep line runs along y, so the axes are exchanged.
  assign steep = dy > dx;
  assign a1    = steep ? start_y : start_x;
  assign b1    = steep ? start_x : start_y;
  assign a2    = steep ? end_y   : end_x;
  assign b2    = steep ? end_x   : end_y;

  // Order the endpoints so the major coordinate rises.
  assign swap_ends = a1 > a2;
  assign lo_a      = swap_ends ? a2 : a1;
  assign lo_b      = swap_ends ? b2 : b1;
  assign hi_a      = swap_ends ? a1 : a2;
  assign hi_b      = swap_ends ? b1 : b2;

  always_comb begin
    setup.steep          = steep;
    setup.major_pos      = lo_a;
    setup.major_end      = hi_a;
    setup.minor_pos      = lo_b;
    setup.minor_dir_down = !(lo_b < hi_b);
    setup.delta_major    = hi_a - lo_a;
    setup.delta_minor    = steep ? dx : dy;
    // Error term starts at half the major delta, rounded down.
    setup.error_term     = {2'b00, 1'b0, setup.delta_major[lpg_pkg::COORD_W-1:1]};
  end

endmodule
